@@ rtl/core/imu_moving_average_debias_assert.svh @@
// Assertion macros for the checker of the moving average block.
`ifndef IMU_MOVING_AVERAGE_DEBIAS_ASSERT_SVH
`define IMU_MOVING_AVERAGE_DEBIAS_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define IMA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define IMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/imu_ma_pkg.sv @@
// Shared types and constants of the IMU moving average block.
`timescale 1ns / 1ps

package imu_ma_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int MEAN_W         = 17;
    localparam int USED_W         = 4;
    localparam int NUM_CH         = 6;
    localparam int WINDOW_DEFAULT = 8;

    // One bias register per channel, in the same order as the channels.
    localparam int REG_COUNT   = NUM_CH;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int APB_ADDR_W  = $clog2(REG_COUNT * 4);
    localparam int APB_DATA_W  = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MEAN_W-1:0]   mean_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } top_state_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_ACCUM,
        LN_DIVIDE
    } lane_phase_t;

    typedef struct packed {
        logic start;
        logic drop_oldest;
    } lane_ctrl_t;

    typedef struct packed {
        logic busy;
        logic result_valid;
    } lane_status_t;

endpackage

@@ rtl/core/imu_ma_lane.sv @@
// One channel lane: sample ring, running sum and a restoring divider.
`timescale 1ns / 1ps

module imu_ma_lane #(
    parameter int WINDOW = imu_ma_pkg::WINDOW_DEFAULT,
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    localparam int CNT_W  = $clog2(WINDOW + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  imu_ma_pkg::lane_ctrl_t   ctrl,
    input  logic [SLOT_W-1:0]        slot,
    input  logic [CNT_W-1:0]         count,
    input  imu_ma_pkg::sample_t      sample,
    output imu_ma_pkg::lane_status_t status,
    output imu_ma_pkg::mean_t        mean
);
    import imu_ma_pkg::*;

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W-1:0] oldest_reg;
    sample_t             sample_reg;
    logic                drop_reg;
    logic [CNT_W-1:0]    divisor_reg;

    lane_phase_t              phase_reg, phase_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     result_valid_reg, result_valid_next;
    logic [SUM_W-1:0]         quo_reg, quo_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    mean_t                    mean_reg, mean_next;

    logic signed [SUM_W-1:0]  sum_upd;
    logic [SUM_W-1:0]         sum_mag;
    logic [CNT_W:0]           trial;
    logic                     fits;
    logic [SUM_W-1:0]         quo_step;
    logic [CNT_W-1:0]         rem_step;
    mean_t                    quo_mean;

    // The ring is read before it is overwritten, so the oldest sample is kept.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            oldest_reg     <= ring_mem[slot];
            ring_mem[slot] <= sample;
            sample_reg     <= sample;
            drop_reg       <= ctrl.drop_oldest;
            divisor_reg    <= count;
        end
    end

    always_comb
    begin
        sum_upd = sum_reg + SUM_W'(sample_reg)
                  - (drop_reg ? SUM_W'($signed(oldest_reg)) : SUM_W'(0));
        sum_mag = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);

        trial    = {rem_reg, quo_reg[SUM_W-1]};
        fits     = trial >= {1'b0, divisor_reg};
        rem_step = fits ? CNT_W'(trial - {1'b0, divisor_reg}) : trial[CNT_W-1:0];
        quo_step = {quo_reg[SUM_W-2:0], fits};
        quo_mean = MEAN_W'(quo_step);

        phase_next        = phase_reg;
        sum_next          = sum_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        neg_next          = neg_reg;
        mean_next         = mean_reg;

        case (phase_reg)
            LN_IDLE:
            begin
                if (ctrl.start)
                begin
                    phase_next        = LN_ACCUM;
                    result_valid_next = 1'b0;
                end
            end
            LN_ACCUM:
            begin
                sum_next   = sum_upd;
                quo_next   = sum_mag;
                neg_next   = sum_upd[SUM_W-1];
                rem_next   = '0;
                step_next  = '0;
                phase_next = LN_DIVIDE;
            end
            LN_DIVIDE:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    mean_next         = neg_reg ? -quo_mean : quo_mean;
                    result_valid_next = 1'b1;
                    phase_next        = LN_IDLE;
                end
            end
            default:
            begin
                phase_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= LN_IDLE;
            sum_reg          <= '0;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            sum_reg          <= sum_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
    end

    assign status.busy         = phase_reg != LN_IDLE;
    assign status.result_valid = result_valid_reg;
    assign mean                = mean_reg;

endmodule

@@ rtl/core/imu_ma_merge.sv @@
// Merging stage: takes the lane means, removes the biases and holds the result.
`timescale 1ns / 1ps

module imu_ma_merge #(
    parameter int WINDOW = imu_ma_pkg::WINDOW_DEFAULT,
    localparam int CNT_W = $clog2(WINDOW + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  imu_ma_pkg::mean_t                   lane_mean [imu_ma_pkg::NUM_CH],
    input  imu_ma_pkg::sample_t                 bias [imu_ma_pkg::NUM_CH],
    input  logic [CNT_W-1:0]                    count,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                free,
    output imu_ma_pkg::mean_t                   result_mean [imu_ma_pkg::NUM_CH],
    output logic [imu_ma_pkg::USED_W-1:0]       samples_used
);
    import imu_ma_pkg::*;

    logic                out_valid_reg, out_valid_next;
    mean_t               mean_reg [NUM_CH];
    logic [USED_W-1:0]   used_reg;

    assign free           = !out_valid_reg || !out_stall;
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                mean_reg[ch] <= MEAN_W'((MEAN_W + 1)'(lane_mean[ch])
                                        - (MEAN_W + 1)'(bias[ch]));
            end
            used_reg <= USED_W'({{USED_W{1'b0}}, count});
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_mean  = mean_reg;
    assign samples_used = used_reg;

endmodule

@@ rtl/core/imu_moving_average_debias.sv @@
// Top level of the six-channel IMU moving average with bias removal.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  input   | in_valid / in_stall    | gyro_x..z, accel_x..z (16-bit signed)
//  output  | out_valid / out_stall  | gyro_x_mean..accel_z_mean (17-bit), samples_used
//  config  | APB psel/penable/...   | six 16-bit signed bias registers at 4*i
//
// Each lane divides its running sum of SUM_W = 16 + clog2(WINDOW) bits by the
// fill count in a restoring divider, which yields one quotient bit a cycle.
// There is no clearing pass after reset: a ring slot's old value is only used
// once the slot has been written. in_stall is high from acceptance until the
// result is loaded into the output register, where it waits, so the next item
// is taken while out_stall holds the last one.
`timescale 1ns / 1ps

module imu_moving_average_debias #(
    parameter int WINDOW = imu_ma_pkg::WINDOW_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [imu_ma_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [imu_ma_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [imu_ma_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  imu_ma_pkg::sample_t                gyro_x,
    input  imu_ma_pkg::sample_t                gyro_y,
    input  imu_ma_pkg::sample_t                gyro_z,
    input  imu_ma_pkg::sample_t                accel_x,
    input  imu_ma_pkg::sample_t                accel_y,
    input  imu_ma_pkg::sample_t                accel_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output imu_ma_pkg::mean_t                  gyro_x_mean,
    output imu_ma_pkg::mean_t                  gyro_y_mean,
    output imu_ma_pkg::mean_t                  gyro_z_mean,
    output imu_ma_pkg::mean_t                  accel_x_mean,
    output imu_ma_pkg::mean_t                  accel_y_mean,
    output imu_ma_pkg::mean_t                  accel_z_mean,
    output logic [imu_ma_pkg::USED_W-1:0]      samples_used
);
    import imu_ma_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // Configuration registers. Writes to an index beyond the list are dropped.
    sample_t              bias_reg [NUM_CH];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 reg_hit;
    logic                 apb_write;

    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign reg_hit   = 32'(reg_idx) < REG_COUNT;
    assign apb_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = reg_hit ? APB_DATA_W'(bias_reg[reg_idx]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                bias_reg[ch] <= '0;
            end
        end
        else if (apb_write && reg_hit)
        begin
            bias_reg[reg_idx] <= sample_t'(pwdata[SAMPLE_W-1:0]);
        end
    end

    // Sequencer: one item at a time, the ring position and fill count live here.
    top_state_t          state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                accept;
    logic                fill_full;
    logic                load;
    logic                free;
    logic [NUM_CH-1:0]   lane_valid;
    logic [NUM_CH-1:0]   lane_busy;
    lane_ctrl_t          lane_ctrl;
    lane_status_t        lane_status [NUM_CH];
    sample_t             lane_sample [NUM_CH];
    mean_t               lane_mean [NUM_CH];
    mean_t               result_mean [NUM_CH];

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != ST_IDLE;
    assign fill_full = fill_reg == CNT_W'(WINDOW);

    assign lane_ctrl.start       = accept;
    assign lane_ctrl.drop_oldest = fill_full;

    assign lane_sample[0] = gyro_x;
    assign lane_sample[1] = gyro_y;
    assign lane_sample[2] = gyro_z;
    assign lane_sample[3] = accel_x;
    assign lane_sample[4] = accel_y;
    assign lane_sample[5] = accel_z;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        load       = 1'b0;

        if (accept)
        begin
            slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            fill_next = fill_full ? fill_reg : fill_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                // All lanes finish together; the result waits for the output register.
                if ((&lane_valid) && !(|lane_busy) && free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            fill_reg  <= fill_next;
        end
    end

    // Six identical lanes, one per channel, each with its own ring and divider.
    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        imu_ma_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .slot   (slot_reg),
            .count  (fill_next),
            .sample (lane_sample[ch]),
            .status (lane_status[ch]),
            .mean   (lane_mean[ch])
        );

        assign lane_valid[ch] = lane_status[ch].result_valid;
        assign lane_busy[ch]  = lane_status[ch].busy;
    end

    imu_ma_merge #(
        .WINDOW (WINDOW)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .lane_mean    (lane_mean),
        .bias         (bias_reg),
        .count        (fill_reg),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .free         (free),
        .result_mean  (result_mean),
        .samples_used (samples_used)
    );

    assign gyro_x_mean  = result_mean[0];
    assign gyro_y_mean  = result_mean[1];
    assign gyro_z_mean  = result_mean[2];
    assign accel_x_mean = result_mean[3];
    assign accel_y_mean = result_mean[4];
    assign accel_z_mean = result_mean[5];

endmodule

@@ rtl/core/imu_ma_checker.sv @@
// Port-level checker of the moving average block and its bind to the top level.
`timescale 1ns / 1ps
`include "imu_moving_average_debias_assert.svh"

module imu_ma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [16:0] gyro_x_mean,
    input logic [16:0] gyro_y_mean,
    input logic [16:0] gyro_z_mean,
    input logic [16:0] accel_x_mean,
    input logic [16:0] accel_y_mean,
    input logic [16:0] accel_z_mean,
    input logic [3:0]  samples_used
);

    // An accepted item keeps the block busy for at least the following cycle.
    `IMA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")

    // A new result only appears at the end of an item's work.
    `IMA_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result from nothing")

    // The block only falls idle by handing a result to the output register.
    `IMA_ASSERT_SAME(a_idle_with_result, $fell(in_stall), out_valid, "idle without result")

    `IMA_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid, "stalled result dropped")

    `IMA_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(gyro_x_mean) && $stable(gyro_y_mean) && $stable(gyro_z_mean) &&
        $stable(accel_x_mean) && $stable(accel_y_mean) && $stable(accel_z_mean) &&
        $stable(samples_used), "stalled result changed")

endmodule

bind imu_moving_average_debias imu_ma_checker u_imu_ma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gyro_x_mean  (gyro_x_mean),
    .gyro_y_mean  (gyro_y_mean),
    .gyro_z_mean  (gyro_z_mean),
    .accel_x_mean (accel_x_mean),
    .accel_y_mean (accel_y_mean),
    .accel_z_mean (accel_z_mean),
    .samples_used (samples_used)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for the six-channel IMU moving average with bias removal.
`timescale 1ns / 1ps

module tb_top;
    import imu_ma_pkg::*;

    // The block is built with its default window, so the model here uses the same.
    localparam int WIN             = WINDOW_DEFAULT;
    localparam int SAMPLE_MAX      = 32767;
    localparam int SAMPLE_MIN      = -32768;
    // Even with long random stalls on both sides, a correct block should never
    // leave the bench quiet for anywhere near this many cycles.
    localparam int IDLE_LIMIT      = 5000;
    // Cycles allowed after the last mean before registers are touched or the run ends.
    localparam int SETTLE_CYCLES   = 40;
    localparam int ITEMS_PER_PHASE = 420;
    localparam int NUM_PHASES      = 4;

    // Register map: one bias per channel at byte address 4*i. The last two
    // entries decode to no register and must leave the biases untouched.
    typedef enum int {
        REG_GYRO_BIAS_X,
        REG_GYRO_BIAS_Y,
        REG_GYRO_BIAS_Z,
        REG_ACCEL_BIAS_X,
        REG_ACCEL_BIAS_Y,
        REG_ACCEL_BIAS_Z,
        REG_UNMAPPED_LO,
        REG_UNMAPPED_HI
    } bias_reg_t;

    // Element 0 is gyro x and element 5 is accel z, the same order as the registers.
    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] imu_sample_t;

    typedef struct packed {
        logic [NUM_CH-1:0][MEAN_W-1:0] mean;
        logic [USED_W-1:0]             used;
    } window_mean_t;

    // The scoreboard keeps its own copy of the window, the sums and the biases.
    // Every accepted sample produces exactly one expected mean, checked in order.
    class mean_scoreboard;
        int           ring [WIN][NUM_CH];
        int           sums [NUM_CH];
        int           bias [NUM_CH];
        int           slot;
        int           fill;
        window_mean_t pending_q[$];
        int           errors;
        int           n_samples;
        int           n_checked;
        string        chan [NUM_CH];

        function new();
            chan = '{"gyro_x_mean", "gyro_y_mean", "gyro_z_mean",
                     "accel_x_mean", "accel_y_mean", "accel_z_mean"};
        endfunction

        // Writes to addresses beyond the last register are dropped by the block.
        function void write_bias(int idx, logic [APB_DATA_W-1:0] data);
            if (idx < NUM_CH)
                bias[idx] = int'($signed(data[SAMPLE_W-1:0]));
        endfunction

        function void check_readback(int idx, logic [APB_DATA_W-1:0] data);
            if (data[SAMPLE_W-1:0] !== SAMPLE_W'(bias[idx])) begin
                $display("%0t: bias register %0d read back: expected %0d, actual %0d",
                         $time, idx, bias[idx], $signed(data[SAMPLE_W-1:0]));
                errors++;
            end
        endfunction

        // Once the window is full the oldest sample drops out of each sum. The
        // mean truncates toward zero, which is what signed int division does.
        function void note_sample(imu_sample_t s);
            window_mean_t m;
            int           k;
            bit           full;
            full = (fill >= WIN);
            for (k = 0; k < NUM_CH; k++) begin
                if (full)
                    sums[k] -= ring[slot][k];
                ring[slot][k] = int'($signed(s[k]));
                sums[k] += ring[slot][k];
            end
            slot = (slot + 1) % WIN;
            if (fill < WIN)
                fill++;
            for (k = 0; k < NUM_CH; k++)
                m.mean[k] = MEAN_W'(sums[k] / fill - bias[k]);
            m.used = USED_W'(fill);
            pending_q.push_back(m);
            n_samples++;
        endfunction

        function void check_mean(window_mean_t got);
            window_mean_t want;
            int           k;
            if (pending_q.size() == 0) begin
                $display("%0t: mean with no sample outstanding: expected none, actual %s %0d",
                         $time, chan[0], $signed(got.mean[0]));
                errors++;
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            for (k = 0; k < NUM_CH; k++) begin
                if (got.mean[k] !== want.mean[k]) begin
                    $display("%0t: %s expected %0d, actual %0d", $time, chan[k],
                             $signed(want.mean[k]), $signed(got.mean[k]));
                    errors++;
                end
            end
            if (got.used !== want.used) begin
                $display("%0t: samples_used expected %0d, actual %0d",
                         $time, want.used, got.used);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    sample_t               gyro_x;
    sample_t               gyro_y;
    sample_t               gyro_z;
    sample_t               accel_x;
    sample_t               accel_y;
    sample_t               accel_z;
    logic                  out_valid;
    logic                  out_stall;
    mean_t                 gyro_x_mean;
    mean_t                 gyro_y_mean;
    mean_t                 gyro_z_mean;
    mean_t                 accel_x_mean;
    mean_t                 accel_y_mean;
    mean_t                 accel_z_mean;
    logic [USED_W-1:0]     samples_used;

    mean_scoreboard sb = new();

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    int n_cfg_writes  = 0;
    bit activity;

    imu_moving_average_debias dut (.*);

    always #1 clk = ~clk;

    // The receiver decides afresh at every falling edge whether to stall.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // All handshakes are observed here at the rising edge, before the block's
    // registers update. A mean leaving at the same edge as a sample arrives
    // belongs to an earlier sample, so it is checked before the new one is noted.
    // The same block runs the watchdog, which counts cycles with no transfer.
    always @(posedge clk) begin
        if (rst_n) begin
            activity = 1'b0;
            if (out_valid && !out_stall) begin
                sb.check_mean({accel_z_mean, accel_y_mean, accel_x_mean,
                               gyro_z_mean, gyro_y_mean, gyro_x_mean, samples_used});
                activity = 1'b1;
            end
            if (in_valid && !in_stall) begin
                sb.note_sample({accel_z, accel_y, accel_x, gyro_z, gyro_y, gyro_x});
                activity = 1'b1;
            end
            if (psel && penable && pready) begin
                if (pwrite)
                    sb.write_bias(int'(paddr >> 2), pwdata);
                activity = 1'b1;
            end
            if (activity)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Presents one sample, after a random number of idle cycles, and holds it
    // steady until the block takes it. Every driving task starts at a falling
    // edge, so each input is assigned at most once per time step.
    task automatic send_sample(imu_sample_t s);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        gyro_x   <= s[0];
        gyro_y   <= s[1];
        gyro_z   <= s[2];
        accel_x  <= s[3];
        accel_y  <= s[4];
        accel_z  <= s[5];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic apb_write(bias_reg_t r, logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(r) * 4);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        n_cfg_writes++;
    endtask

    task automatic apb_read(bias_reg_t r, output logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(int'(r) * 4);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_biases();
        logic [APB_DATA_W-1:0] data;
        for (int r = 0; r < NUM_CH; r++) begin
            apb_read(bias_reg_t'(r), data);
            sb.check_readback(r, data);
        end
    endtask

    // Drops the valid, waits for every outstanding mean and then lets the block
    // settle, so that registers are only ever written while it is idle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_all_biases(int value);
        for (int r = 0; r < NUM_CH; r++)
            apb_write(bias_reg_t'(r), APB_DATA_W'(value));
        verify_biases();
    endtask

    // Warm-up samples: all ones, all zeros, channels swinging between the extremes,
    // then small values from -3 to 2, so that odd sums exercise truncation toward zero on both signs.
    function automatic imu_sample_t warmup_sample(int n);
        imu_sample_t s;
        for (int k = 0; k < NUM_CH; k++) begin
            if (n == 0)
                s[k] = '1;
            else if (n == 1)
                s[k] = '0;
            else if (n == 7)
                s[k] = SAMPLE_W'(k - 3);
            else
                s[k] = ((k + n) % 2 != 0) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN);
        end
        return s;
    endfunction

    function automatic int random_bias();
        case ($urandom_range(0, 3))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return 0;
            default: return int'($signed(SAMPLE_W'($urandom)));
        endcase
    endfunction

    // Random samples: uniform counts, extremes and small values near zero, a slowly drifting
    // signal like a real sensor and held values that fill the window with one value.
    function automatic imu_sample_t random_sample(imu_sample_t prev);
        imu_sample_t s;
        int          pick;
        pick = $urandom_range(0, 99);
        for (int k = 0; k < NUM_CH; k++) begin
            if (pick < 45)
                s[k] = SAMPLE_W'($urandom);
            else if (pick < 65) begin
                case ($urandom_range(0, 4))
                    0:       s[k] = SAMPLE_W'(SAMPLE_MIN);
                    1:       s[k] = SAMPLE_W'(SAMPLE_MAX);
                    2:       s[k] = '1;
                    3:       s[k] = '0;
                    default: s[k] = SAMPLE_W'(1);
                endcase
            end
            else if (pick < 90)
                s[k] = prev[k] + SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
            else
                s[k] = prev[k];
        end
        return s;
    endfunction

    initial begin
        imu_sample_t last;
        int          idle_set [NUM_PHASES];
        int          stall_set [NUM_PHASES];

        // Traffic phases: free flowing, a sparse sender, a reluctant receiver,
        // and both holding back now and then.
        idle_set  = '{0, 87, 0, 24};
        stall_set = '{0, 0, 87, 24};

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        gyro_x    = '0;
        gyro_y    = '0;
        gyro_z    = '0;
        accel_x   = '0;
        accel_y   = '0;
        accel_z   = '0;
        last      = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The biases must read back as zero straight after reset. The first
        // eight samples then show the window filling from one sample to full.
        verify_biases();
        for (int n = 0; n < WIN; n++)
            send_sample(warmup_sample(n));
        drain();

        // Largest negative mean minus the largest bias gives the lowest result,
        // and the window wraps onto a full set of the most negative samples.
        set_all_biases(SAMPLE_MAX);
        for (int n = 0; n < WIN; n++)
            send_sample({NUM_CH{SAMPLE_W'(SAMPLE_MIN)}});
        drain();

        // And the reverse for the highest result.
        set_all_biases(SAMPLE_MIN);
        for (int n = 0; n < WIN; n++)
            send_sample({NUM_CH{SAMPLE_W'(SAMPLE_MAX)}});
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Fresh biases per phase, plus writes to the two unmapped addresses
            // with random data, which the read-back shows had no effect.
            for (int r = 0; r < NUM_CH; r++)
                apb_write(bias_reg_t'(r), APB_DATA_W'(random_bias()));
            apb_write(REG_UNMAPPED_LO, APB_DATA_W'($urandom));
            apb_write(REG_UNMAPPED_HI, APB_DATA_W'($urandom));
            verify_biases();

            send_idle_pct = idle_set[p];
            stall_pct     = stall_set[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                last = random_sample(last);
                send_sample(last);
            end
            drain();
        end

        $display("summary: %0d samples sent, %0d means checked, %0d register writes",
                 sb.n_samples, sb.n_checked, n_cfg_writes);
        $display("summary: window filled and wrapped, bias extremes and %0d traffic phases",
                 NUM_PHASES);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
